[design/bvre_pkg.sv]
`timescale 1ns / 1ps

package bvre_pkg;

    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = 64;
    localparam int MAX_BITS  = 4096;
    localparam int CAP_W     = 13;
    localparam int IDX_W     = 12;
    localparam int WADDR_W   = 6;

    // operation codes
    localparam logic [4:0] OP_READ    = 5'd0;
    localparam logic [4:0] OP_WRITE   = 5'd1;
    localparam logic [4:0] OP_FLIP    = 5'd2;
    localparam logic [4:0] OP_SETRNG  = 5'd3;
    localparam logic [4:0] OP_CLRRNG  = 5'd4;
    localparam logic [4:0] OP_FLIPRNG = 5'd5;
    localparam logic [4:0] OP_COUNT   = 5'd6;
    localparam logic [4:0] OP_NXTSET  = 5'd7;
    localparam logic [4:0] OP_PRVSET  = 5'd8;
    localparam logic [4:0] OP_NXTCLR  = 5'd9;
    localparam logic [4:0] OP_PRVCLR  = 5'd10;
    localparam logic [4:0] OP_SHDOWN  = 5'd11;
    localparam logic [4:0] OP_SHUP    = 5'd12;
    localparam logic [4:0] OP_OR      = 5'd13;
    localparam logic [4:0] OP_AND     = 5'd14;
    localparam logic [4:0] OP_XOR     = 5'd15;
    localparam logic [4:0] OP_RDWORD  = 5'd16;

    // register index (byte address bit 2)
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    typedef struct packed {
        logic [4:0]           opcode;
        logic [IDX_W-1:0]     first_index;
        logic [IDX_W-1:0]     last_index;
        logic [IDX_W-1:0]     shift_amount;
        logic                 bit_value;
        logic [WADDR_W-1:0]   word_index;
        logic [WORD_BITS-1:0] word_data;
    } bvre_req_t;

    typedef struct packed {
        logic signed [13:0]   position;
        logic [CAP_W-1:0]     population;
        logic                 bit_out;
        logic [WORD_BITS-1:0] word_out;
    } bvre_rsp_t;

    typedef struct packed {
        logic             wr;
        logic [CAP_W-1:0] cap;
    } bvre_cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MOD,
        S_WALK,
        S_TAIL_RD,
        S_TAIL_WR,
        S_RESULT
    } bvre_state_t;

    function automatic logic [CAP_W-1:0] cap_eff(input logic [CAP_W-1:0] raw);
        logic [CAP_W-1:0] c;
        c = raw;
        if (raw == '0)
        begin
            c = 13'd1;
        end
        else if (raw > 13'(MAX_BITS))
        begin
            c = 13'(MAX_BITS);
        end
        return c;
    endfunction

    function automatic logic [WORD_BITS-1:0] tail_mask(input logic [CAP_W-1:0] cap);
        logic [WORD_BITS-1:0] m;
        if (cap[5:0] == 6'd0)
        begin
            m = '1;
        end
        else
        begin
            m = (64'd1 << cap[5:0]) - 64'd1;
        end
        return m;
    endfunction

    function automatic logic [6:0] popcount64(input logic [WORD_BITS-1:0] v);
        logic [6:0] s;
        s = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            s = s + {6'd0, v[i]};
        end
        return s;
    endfunction

    function automatic logic [5:0] lsb64(input logic [WORD_BITS-1:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [5:0] msb64(input logic [WORD_BITS-1:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

[design/bvre_ram.sv]
`timescale 1ns / 1ps

module bvre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/bvre_seq.sv]
`timescale 1ns / 1ps

module bvre_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [12:0]        cap,
    input  bvre_pkg::bvre_cfg_t cfg,
    input  logic               req_valid,
    output logic               req_ready,
    input  bvre_pkg::bvre_req_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output bvre_pkg::bvre_rsp_t rsp
);
    import bvre_pkg::*;

    bvre_state_t state_reg, state_next;

    logic [4:0]           op_reg, op_next;
    logic [11:0]          first_reg, first_next;
    logic                 bv_reg, bv_next;
    logic [63:0]          wd_reg, wd_next;
    logic [5:0]           start_reg, start_next;
    logic [5:0]           end_reg, end_next;
    logic [5:0]           lo_reg, lo_next;
    logic [5:0]           hi_reg, hi_next;
    logic [5:0]           q_reg, q_next;
    logic [5:0]           r_reg, r_next;
    logic signed [7:0]    rp_reg, rp_next;
    logic signed [7:0]    pp_reg;
    logic                 walk_q_reg;
    logic [63:0]          prev_reg, prev_next;
    logic [12:0]          pop_reg, pop_next;
    logic signed [13:0]   pos_reg, pos_next;
    logic                 bit_reg, bit_next;
    logic [63:0]          wout_reg, wout_next;
    logic                 pend_reg, pend_next;
    logic [12:0]          pend_cap_reg, pend_cap_next;
    logic                 cfg_hit_reg;
    logic [63:0]          vld_reg, vld_next;
    logic                 rd_vld_reg;

    logic                 we;
    logic [5:0]           waddr;
    logic [63:0]          wdata;
    logic [63:0]          rdata;
    logic [63:0]          d;

    logic [11:0]          capm1;
    logic [5:0]           lastw;
    logic [63:0]          tmask;
    logic [11:0]          last_cl;
    logic [11:0]          s_cl;
    logic [11:0]          pend_capm1;
    logic [11:0]          cfg_capm1;
    logic [63:0]          keep_mask;
    logic [63:0]          set_mask;

    logic                 down_dir;
    logic [63:0]          rmask;
    logic [63:0]          want_v;
    logic [63:0]          sv;
    logic signed [8:0]    jj;
    logic                 j_in;
    logic [63:0]          sh_word;
    logic [5:0]           rinv;
    logic [5:0]           off;
    logic                 nbit;
    logic [63:0]          mword;

    bvre_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rp_reg[5:0]),
        .rdata (rdata)
    );

    assign capm1      = 12'(cap - 13'd1);
    assign lastw      = capm1[11:6];
    assign tmask      = tail_mask(cap);
    assign pend_capm1 = 12'(pend_cap_reg - 13'd1);
    assign cfg_capm1  = 12'(cfg.cap - 13'd1);

    // words that were never written or lie off the store read as zero
    assign d = (rd_vld_reg && !pp_reg[7] && !pp_reg[6]) ? rdata : '0;

    assign req_ready = (state_reg == S_IDLE) && !pend_reg;
    assign rsp_valid = (state_reg == S_RESULT);
    assign rsp.position   = pos_reg;
    assign rsp.population = pop_reg;
    assign rsp.bit_out    = bit_reg;
    assign rsp.word_out   = wout_reg;

    // drop words above a newly written capacity; mark written words
    always_comb
    begin
        keep_mask = '1;
        if (cfg.wr)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                if (6'(i) > cfg_capm1[11:6])
                begin
                    keep_mask[i] = 1'b0;
                end
            end
        end
        set_mask = '0;
        if (we)
        begin
            set_mask[waddr] = 1'b1;
        end
        vld_next = (vld_reg | set_mask) & keep_mask;
    end

    // track the pending tail trim after capacity writes
    always_comb
    begin
        pend_next     = pend_reg;
        pend_cap_next = pend_cap_reg;
        if (cfg.wr)
        begin
            pend_next = 1'b1;
            if (pend_reg && (pend_cap_reg < cfg.cap))
            begin
                pend_cap_next = pend_cap_reg;
            end
            else
            begin
                pend_cap_next = cfg.cap;
            end
        end
        else if ((state_reg == S_TAIL_WR) && !cfg_hit_reg)
        begin
            pend_next = 1'b0;
        end
    end

    // walk datapath helpers
    always_comb
    begin
        down_dir = (op_reg == OP_PRVSET) || (op_reg == OP_PRVCLR) || (op_reg == OP_SHUP);
        rmask = '1;
        if (pp_reg[5:0] == start_reg)
        begin
            rmask = rmask & ('1 << lo_reg);
        end
        if (pp_reg[5:0] == end_reg)
        begin
            rmask = rmask & ('1 >> (6'd63 - hi_reg));
        end
        want_v = ((op_reg == OP_NXTSET) || (op_reg == OP_PRVSET)) ? d : ~d;
        sv = want_v;
        if ((op_reg == OP_NXTSET) || (op_reg == OP_NXTCLR))
        begin
            if (pp_reg[5:0] == start_reg)
            begin
                sv = sv & ('1 << lo_reg);
            end
            if (pp_reg[5:0] == lastw)
            begin
                sv = sv & tmask;
            end
        end
        else
        begin
            if (pp_reg[5:0] == start_reg)
            begin
                sv = sv & ('1 >> (6'd63 - hi_reg));
            end
        end
        if (op_reg == OP_SHUP)
        begin
            jj = {pp_reg[7], pp_reg} + {3'b000, q_reg} + 9'sd1;
        end
        else
        begin
            jj = {pp_reg[7], pp_reg} - {3'b000, q_reg} - 9'sd1;
        end
        j_in = !jj[8] && (jj[7:6] == 2'b00) && (jj[5:0] <= lastw);
        rinv = 6'(7'd64 - {1'b0, r_reg});
        if (r_reg == 6'd0)
        begin
            sh_word = prev_reg;
        end
        else if (op_reg == OP_SHUP)
        begin
            sh_word = (prev_reg << r_reg) | (d >> rinv);
        end
        else
        begin
            sh_word = (prev_reg >> r_reg) | (d << rinv);
        end
        if (jj[5:0] == lastw)
        begin
            sh_word = sh_word & tmask;
        end
        off  = first_reg[5:0];
        nbit = d[off];
        if (op_reg == OP_WRITE)
        begin
            nbit = bv_reg;
        end
        else if (op_reg == OP_FLIP)
        begin
            nbit = ~d[off];
        end
        mword = d;
        case (op_reg)
            OP_OR:   mword = d | wd_reg;
            OP_AND:  mword = d & wd_reg;
            OP_XOR:  mword = d ^ wd_reg;
            default: mword = d;
        endcase
        if (pp_reg[5:0] == lastw)
        begin
            mword = mword & tmask;
        end
    end

    assign last_cl = (req.last_index > capm1) ? capm1 : req.last_index;
    assign s_cl    = (req.first_index > capm1) ? capm1 : req.first_index;

    // sequencer: next state, memory port and result
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        first_next = first_reg;
        bv_next    = bv_reg;
        wd_next    = wd_reg;
        start_next = start_reg;
        end_next   = end_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        rp_next    = rp_reg;
        prev_next  = prev_reg;
        pop_next   = pop_reg;
        pos_next   = pos_reg;
        bit_next   = bit_reg;
        wout_next  = wout_reg;
        we         = 1'b0;
        waddr      = pp_reg[5:0];
        wdata      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    op_next    = req.opcode;
                    first_next = req.first_index;
                    bv_next    = req.bit_value;
                    wd_next    = req.word_data;
                    pop_next   = '0;
                    pos_next   = '0;
                    bit_next   = 1'b0;
                    wout_next  = '0;
                    state_next = S_RESULT;
                    case (req.opcode)
                        OP_READ, OP_WRITE, OP_FLIP:
                        begin
                            if (req.first_index <= capm1)
                            begin
                                rp_next    = {2'b00, req.first_index[11:6]};
                                state_next = S_RD;
                            end
                        end
                        OP_SETRNG, OP_CLRRNG, OP_FLIPRNG, OP_COUNT:
                        begin
                            if (req.first_index <= last_cl)
                            begin
                                start_next = req.first_index[11:6];
                                end_next   = last_cl[11:6];
                                lo_next    = req.first_index[5:0];
                                hi_next    = last_cl[5:0];
                                rp_next    = {2'b00, req.first_index[11:6]};
                                state_next = S_WALK;
                            end
                        end
                        OP_NXTSET, OP_NXTCLR:
                        begin
                            if (req.first_index > capm1)
                            begin
                                pos_next = {1'b0, cap};
                            end
                            else
                            begin
                                start_next = req.first_index[11:6];
                                lo_next    = req.first_index[5:0];
                                rp_next    = {2'b00, req.first_index[11:6]};
                                state_next = S_WALK;
                            end
                        end
                        OP_PRVSET, OP_PRVCLR:
                        begin
                            start_next = s_cl[11:6];
                            hi_next    = s_cl[5:0];
                            rp_next    = {2'b00, s_cl[11:6]};
                            state_next = S_WALK;
                        end
                        OP_SHDOWN:
                        begin
                            q_next     = req.shift_amount[11:6];
                            r_next     = req.shift_amount[5:0];
                            rp_next    = {2'b00, req.shift_amount[11:6]};
                            state_next = S_WALK;
                        end
                        OP_SHUP:
                        begin
                            q_next     = req.shift_amount[11:6];
                            r_next     = req.shift_amount[5:0];
                            rp_next    = $signed({2'b00, lastw})
                                       - $signed({2'b00, req.shift_amount[11:6]});
                            state_next = S_WALK;
                        end
                        OP_OR, OP_AND, OP_XOR, OP_RDWORD:
                        begin
                            if (req.word_index <= lastw)
                            begin
                                rp_next    = {2'b00, req.word_index};
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
                else if (pend_reg)
                begin
                    rp_next    = {2'b00, pend_capm1[11:6]};
                    state_next = S_TAIL_RD;
                end
            end

            S_RD:
            begin
                state_next = S_MOD;
            end

            S_MOD:
            begin
                // modify the single word and write it back (reads leave it unchanged)
                state_next = S_RESULT;
                if ((op_reg == OP_READ) || (op_reg == OP_WRITE) || (op_reg == OP_FLIP))
                begin
                    bit_next = nbit;
                    wdata    = d;
                    wdata[off] = nbit;
                    we       = (op_reg != OP_READ);
                end
                else
                begin
                    wout_next = mword;
                    wdata     = mword;
                    we        = (op_reg != OP_RDWORD);
                end
            end

            S_WALK:
            begin
                rp_next = down_dir ? rp_reg - 8'sd1 : rp_reg + 8'sd1;
                if (walk_q_reg)
                begin
                    case (op_reg)
                        OP_SETRNG, OP_CLRRNG, OP_FLIPRNG, OP_COUNT:
                        begin
                            case (op_reg)
                                OP_SETRNG:  wdata = d | rmask;
                                OP_CLRRNG:  wdata = d & ~rmask;
                                default:    wdata = d ^ rmask;
                            endcase
                            we = (op_reg != OP_COUNT);
                            if (op_reg == OP_COUNT)
                            begin
                                pop_next = pop_reg + {6'd0, popcount64(d & rmask)};
                            end
                            if (pp_reg[5:0] == end_reg)
                            begin
                                state_next = S_RESULT;
                            end
                        end
                        OP_NXTSET, OP_NXTCLR:
                        begin
                            if (sv != '0)
                            begin
                                pos_next   = {2'b00, pp_reg[5:0], lsb64(sv)};
                                state_next = S_RESULT;
                            end
                            else if (pp_reg[5:0] == lastw)
                            begin
                                pos_next   = {1'b0, cap};
                                state_next = S_RESULT;
                            end
                        end
                        OP_PRVSET, OP_PRVCLR:
                        begin
                            if (sv != '0)
                            begin
                                pos_next   = {2'b00, pp_reg[5:0], msb64(sv)};
                                state_next = S_RESULT;
                            end
                            else if (pp_reg[5:0] == 6'd0)
                            begin
                                pos_next   = '1;
                                state_next = S_RESULT;
                            end
                        end
                        default:
                        begin
                            // whole-vector shift: one destination word per step
                            prev_next = d;
                            waddr     = jj[5:0];
                            wdata     = sh_word;
                            we        = j_in;
                            if (j_in && (op_reg == OP_SHUP) && (jj[5:0] == 6'd0))
                            begin
                                state_next = S_RESULT;
                            end
                            if (j_in && (op_reg != OP_SHUP) && (jj[5:0] == lastw))
                            begin
                                state_next = S_RESULT;
                            end
                        end
                    endcase
                end
            end

            S_TAIL_RD:
            begin
                state_next = S_TAIL_WR;
            end

            S_TAIL_WR:
            begin
                // clear bits above the capacity in its last word
                we         = 1'b1;
                wdata      = d & tail_mask(pend_cap_reg);
                state_next = S_IDLE;
            end

            S_RESULT:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pend_reg     <= 1'b0;
            pend_cap_reg <= CAP_RESET;
            cfg_hit_reg  <= 1'b0;
            vld_reg      <= '0;
            walk_q_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            pend_cap_reg <= pend_cap_next;
            cfg_hit_reg  <= (state_reg == S_TAIL_RD) && cfg.wr;
            vld_reg      <= vld_next;
            walk_q_reg   <= (state_reg == S_WALK);
        end
    end

    // operands, pointers and result
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        first_reg  <= first_next;
        bv_reg     <= bv_next;
        wd_reg     <= wd_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        rp_reg     <= rp_next;
        pp_reg     <= rp_reg;
        rd_vld_reg <= vld_reg[rp_reg[5:0]];
        prev_reg   <= prev_next;
        pop_reg    <= pop_next;
        pos_reg    <= pos_next;
        bit_reg    <= bit_next;
        wout_reg   <= wout_next;
    end

endmodule

[design/bit_vector_range_engine_unit.sv]
`timescale 1ns / 1ps

// Bit vector engine over a 64 x 64-bit word memory, cleared at reset. One request is
// taken at a time and gives one result. Single-bit and word operations read the word,
// modify it and write it back, then give the result. Range, count and search operations
// walk one word per cycle through the memory's read port; shifts step through every word
// in use plus one more. A finished result waits in the output register while the next
// request is taken. A capacity write starts a trim of the last word in use (read, then
// write back); requests are held off until it is done.
module bit_vector_range_engine_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  bvre_pkg::bvre_req_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bvre_pkg::bvre_rsp_t out_data
);
    import bvre_pkg::*;

    logic [12:0] cap_reg;
    logic        wr_en;
    bvre_cfg_t   cfg;
    logic        rsp_valid;
    logic        rsp_ready;
    bvre_rsp_t   rsp;
    logic        out_valid_reg;
    bvre_rsp_t   out_data_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? {19'd0, cap_reg} : 32'd0;

    assign cfg.wr  = wr_en;
    assign cfg.cap = cap_eff(pwdata[12:0]);

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (wr_en)
        begin
            cap_reg <= pwdata[12:0];
        end
    end

    bvre_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_eff(cap_reg)),
        .cfg       (cfg),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req       (in_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // hold the result until it is taken
    assign rsp_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= rsp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_ready && rsp_valid)
        begin
            out_data_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
